>>> hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, off while in reset.
`define ASSERT_CLK(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen on a rising edge.
`define ASSERT_NEVER(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> hw/rtl/mite_pkg.sv
package mite_pkg;

    localparam int MEM_BYTES_DEFAULT = 4096;
    localparam int NUM_REGS          = 32;
    localparam int REG_ADDR_W        = 5;
    localparam int WORD_W            = 32;
    localparam int WORD_BYTES        = 4;

    typedef enum logic [2:0] {
        MODE_ADDI = 3'd0,
        MODE_ANDI = 3'd1,
        MODE_LW   = 3'd2,
        MODE_SW   = 3'd3,
        MODE_BEQ  = 3'd4,
        MODE_BNE  = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_MISALIGNED = 2'd1,
        STATUS_RANGE      = 2'd2
    } status_t;

    typedef struct packed {
        logic [2:0]        mode;
        logic [WORD_W-1:0] instruction_word;
        logic [WORD_W-1:0] current_pc;
    } cmd_t;

    typedef struct packed {
        logic                  write_enable;
        logic [REG_ADDR_W-1:0] write_register;
        logic [WORD_W-1:0]     write_value;
        logic                  branch_taken;
        logic [WORD_W-1:0]     branch_target;
        logic [1:0]            status;
    } rsp_t;

    // Result of the execute pass, held until the request leaves.
    typedef struct packed {
        logic                  we;
        logic [REG_ADDR_W-1:0] wreg;
        logic [WORD_W-1:0]     value;
        logic                  is_load;
        logic                  taken;
        logic [WORD_W-1:0]     target;
        status_t               status;
    } exec_t;

    typedef struct packed {
        logic rd;
        logic wr;
    } mem_op_t;

    typedef struct packed {
        logic                  en;
        logic [REG_ADDR_W-1:0] addr;
        logic [WORD_W-1:0]     data;
    } rf_wr_t;

    function automatic logic [WORD_W-1:0] sext16(input logic [15:0] imm);
        return {{16{imm[15]}}, imm};
    endfunction

endpackage

>>> hw/rtl/mite_regfile.sv
module mite_regfile (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            re,
    input  logic [mite_pkg::REG_ADDR_W-1:0] ra,
    input  logic [mite_pkg::REG_ADDR_W-1:0] rb,
    input  mite_pkg::rf_wr_t                wr,
    output logic [mite_pkg::WORD_W-1:0]     rd_a,
    output logic [mite_pkg::WORD_W-1:0]     rd_b
);
    import mite_pkg::*;

    logic [WORD_W-1:0]   mem_reg [NUM_REGS];
    logic [NUM_REGS-1:0] valid_reg;
    logic [WORD_W-1:0]   rd_a_reg;
    logic [WORD_W-1:0]   rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem_reg[wr.addr] <= wr.data;
        end
    end

    // entries read as zero until first written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.en)
        begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    // write-first on an address collision
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            if (wr.en && wr.addr == ra)
            begin
                rd_a_reg <= wr.data;
            end
            else if (valid_reg[ra])
            begin
                rd_a_reg <= mem_reg[ra];
            end
            else
            begin
                rd_a_reg <= '0;
            end

            if (wr.en && wr.addr == rb)
            begin
                rd_b_reg <= wr.data;
            end
            else if (valid_reg[rb])
            begin
                rd_b_reg <= mem_reg[rb];
            end
            else
            begin
                rd_b_reg <= '0;
            end
        end
    end

    assign rd_a = rd_a_reg;
    assign rd_b = rd_b_reg;

endmodule

>>> hw/rtl/mite_dmem.sv
module mite_dmem #(
    parameter int MEM_BYTES = mite_pkg::MEM_BYTES_DEFAULT,
    parameter int ADDR_W    = $clog2((MEM_BYTES + 3) / 4) + 2
) (
    input  logic                        clk,
    input  mite_pkg::mem_op_t           op,
    input  logic [ADDR_W-1:0]           addr,
    input  logic [mite_pkg::WORD_W-1:0] wdata,
    output logic [mite_pkg::WORD_W-1:0] rdata
);
    import mite_pkg::*;

    localparam int ROWS  = (MEM_BYTES + 3) / 4;
    localparam int ROW_W = ADDR_W - 2;

    logic [3:0][7:0] wbytes;
    logic [7:0]      rd_byte_reg [4];
    logic [1:0]      off_reg;
    logic [3:0][7:0] rbytes;

    assign wbytes = wdata;

    // four byte lanes, byte address b lives in lane b[1:0], row b >> 2
    for (genvar j = 0; j < 4; j++)
    begin : g_lane
        localparam logic [1:0] LANE = 2'(j);

        logic [7:0]       bank_reg [ROWS];
        logic             carry;
        logic [ROW_W-1:0] row;
        logic [1:0]       k;

        assign carry = (addr[1:0] > LANE);
        assign row   = addr[ADDR_W-1:2] + {{(ROW_W-1){1'b0}}, carry};
        assign k     = LANE - addr[1:0];

        always_ff @(posedge clk)
        begin
            if (op.wr)
            begin
                bank_reg[row] <= wbytes[2'd3 - k];
            end
            if (op.rd)
            begin
                rd_byte_reg[j] <= bank_reg[row];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (op.rd)
        begin
            off_reg <= addr[1:0];
        end
    end

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            rbytes[2'd3 - 2'(k)] = rd_byte_reg[off_reg + 2'(k)];
        end
    end

    assign rdata = rbytes;

endmodule

>>> hw/rtl/mite_exec.sv
module mite_exec #(
    parameter int MEM_BYTES = mite_pkg::MEM_BYTES_DEFAULT,
    parameter int ADDR_W    = $clog2((MEM_BYTES + 3) / 4) + 2
) (
    input  logic                        fire,
    input  mite_pkg::cmd_t              req,
    input  logic [mite_pkg::WORD_W-1:0] rs_data,
    input  logic [mite_pkg::WORD_W-1:0] rt_data,
    output mite_pkg::exec_t             res,
    output mite_pkg::mem_op_t           mem_op,
    output logic [ADDR_W-1:0]           mem_addr,
    output logic [mite_pkg::WORD_W-1:0] mem_wdata
);
    import mite_pkg::*;

    localparam logic [WORD_W-1:0] ADDR_LIMIT = WORD_W'(MEM_BYTES - WORD_BYTES);

    logic [REG_ADDR_W-1:0] rt;
    logic [15:0]           imm;
    logic [WORD_W-1:0]     simm;
    logic [WORD_W-1:0]     addr;
    logic                  out_of_range;
    status_t               mem_status;

    always_comb
    begin
        rt           = req.instruction_word[20:16];
        imm          = req.instruction_word[15:0];
        simm         = sext16(imm);
        addr         = rs_data + simm;
        out_of_range = addr > ADDR_LIMIT;
        if (out_of_range)
        begin
            mem_status = STATUS_RANGE;
        end
        else if (addr[1:0] != 2'b00)
        begin
            mem_status = STATUS_MISALIGNED;
        end
        else
        begin
            mem_status = STATUS_OK;
        end
    end

    always_comb
    begin
        res        = '0;
        res.status = STATUS_OK;
        mem_op     = '0;
        mem_addr   = addr[ADDR_W-1:0];
        mem_wdata  = rt_data;

        case (mode_t'(req.mode))
            MODE_ADDI:
            begin
                res.we    = 1'b1;
                res.value = rs_data + simm;
            end
            MODE_ANDI:
            begin
                res.we    = 1'b1;
                res.value = rs_data & {16'h0000, imm};
            end
            MODE_LW:
            begin
                res.status  = mem_status;
                res.we      = !out_of_range;
                res.is_load = !out_of_range;
                mem_op.rd   = fire && !out_of_range;
            end
            MODE_SW:
            begin
                res.status = mem_status;
                mem_op.wr  = fire && !out_of_range;
            end
            MODE_BEQ:
            begin
                res.target = req.current_pc + WORD_W'(WORD_BYTES) + {simm[29:0], 2'b00};
                res.taken  = (rs_data == rt_data);
            end
            MODE_BNE:
            begin
                res.target = req.current_pc + WORD_W'(WORD_BYTES) + {simm[29:0], 2'b00};
                res.taken  = (rs_data != rt_data);
            end
            default:
            begin
            end
        endcase

        // r0 is never written
        if (res.we && rt != '0)
        begin
            res.wreg = rt;
        end
        else
        begin
            res.we      = 1'b0;
            res.wreg    = '0;
            res.value   = '0;
            res.is_load = 1'b0;
        end
    end

endmodule

>>> hw/rtl/mips_itype_execute_unit.sv
// An accepted request is registered in the request stage and then in the result stage, which
// drives rsp_valid. Throughput: one request per cycle while rsp_stall is low; register-file
// hazards are forwarded from the result stage, and the byte-lane data memory takes one access per cycle.
// Reset clears both pipeline stages and reads the register file as all zero;
// data memory contents are undefined until stored.
`include "assert_macros.svh"

module mips_itype_execute_unit #(
    parameter int MEM_BYTES = mite_pkg::MEM_BYTES_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_stall,
    input  mite_pkg::cmd_t cmd,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output mite_pkg::rsp_t rsp
);
    import mite_pkg::*;

    localparam int ADDR_W = $clog2((MEM_BYTES + 3) / 4) + 2;

    logic              accept;
    logic              advance;
    logic              fire;

    logic              s1_valid_reg;
    logic              s1_valid_next;
    cmd_t              s1_req_reg;
    logic              s2_valid_reg;
    logic              s2_valid_next;
    exec_t             s2_exec_reg;

    logic [WORD_W-1:0] rf_rd_a;
    logic [WORD_W-1:0] rf_rd_b;
    rf_wr_t            rf_wr;
    logic [WORD_W-1:0] rs_data;
    logic [WORD_W-1:0] rt_data;
    logic [WORD_W-1:0] s2_value;

    exec_t             exec_res;
    mem_op_t           mem_op;
    logic [ADDR_W-1:0] mem_addr;
    logic [WORD_W-1:0] mem_wdata;
    logic [WORD_W-1:0] mem_rdata;

    assign advance   = !s2_valid_reg || !rsp_stall;
    assign cmd_stall = s1_valid_reg && !advance;
    assign accept    = cmd_valid && !cmd_stall;
    assign fire      = s1_valid_reg && advance;

    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
        s2_valid_next = advance ? s1_valid_reg : s2_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg <= cmd;
        end
        if (fire)
        begin
            s2_exec_reg <= exec_res;
        end
    end

    mite_regfile u_regfile (
        .clk   (clk),
        .rst_n (rst_n),
        .re    (accept),
        .ra    (cmd.instruction_word[25:21]),
        .rb    (cmd.instruction_word[20:16]),
        .wr    (rf_wr),
        .rd_a  (rf_rd_a),
        .rd_b  (rf_rd_b)
    );

    assign s2_value = s2_exec_reg.is_load ? mem_rdata : s2_exec_reg.value;

    // forward the unretired result stage
    always_comb
    begin
        rs_data = rf_rd_a;
        rt_data = rf_rd_b;
        if (s2_valid_reg && s2_exec_reg.we)
        begin
            if (s2_exec_reg.wreg == s1_req_reg.instruction_word[25:21])
            begin
                rs_data = s2_value;
            end
            if (s2_exec_reg.wreg == s1_req_reg.instruction_word[20:16])
            begin
                rt_data = s2_value;
            end
        end
    end

    mite_exec #(
        .MEM_BYTES (MEM_BYTES),
        .ADDR_W    (ADDR_W)
    ) u_exec (
        .fire      (fire),
        .req       (s1_req_reg),
        .rs_data   (rs_data),
        .rt_data   (rt_data),
        .res       (exec_res),
        .mem_op    (mem_op),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata)
    );

    mite_dmem #(
        .MEM_BYTES (MEM_BYTES),
        .ADDR_W    (ADDR_W)
    ) u_dmem (
        .clk   (clk),
        .op    (mem_op),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        rf_wr.en   = s2_valid_reg && !rsp_stall && s2_exec_reg.we;
        rf_wr.addr = s2_exec_reg.wreg;
        rf_wr.data = s2_value;
    end

    assign rsp_valid = s2_valid_reg;

    always_comb
    begin
        rsp.write_enable   = s2_exec_reg.we;
        rsp.write_register = s2_exec_reg.wreg;
        rsp.write_value    = s2_value;
        rsp.branch_taken   = s2_exec_reg.taken;
        rsp.branch_target  = s2_exec_reg.target;
        rsp.status         = s2_exec_reg.status;
    end

    `ASSERT_NEVER(a_no_r0_write, clk, rst_n, rf_wr.en && rf_wr.addr == '0, "write to r0")
    `ASSERT_NEVER(a_mem_one_op, clk, rst_n, mem_op.rd && mem_op.wr, "load and store together")
    `ASSERT_CLK(a_s1_moves, clk, rst_n, (s1_valid_reg && s2_valid_reg && !rsp_stall) |=> s2_valid_reg, "request lost between stages")
    `ASSERT_CLK(a_range_no_write, clk, rst_n, (rsp_valid && rsp.status == STATUS_RANGE) |-> !rsp.write_enable, "suppressed access wrote a register")

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
    import mite_pkg::*;

    localparam int MEM_BYTES    = MEM_BYTES_DEFAULT;
    localparam int N_DIRECTED   = 25;
    localparam int N_RANDOM     = 700;
    localparam int LONG_HOLD    = 120;
    localparam int DRAIN_CYCLES = 8;
    localparam int TIMEOUT_NS   = 2_000_000;

    localparam logic [2:0] MODE_RSVD_A = 3'd6;
    localparam logic [2:0] MODE_RSVD_B = 3'd7;

    typedef struct packed {
        logic [2:0]  mode;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [15:0] imm;
        logic [31:0] pc;
        logic        has_fixed;
        rsp_t        fixed;
    } dir_row_t;

    // Base register r4 = 0x100; rows after that build on the memory they wrote.
    localparam dir_row_t DIRECTED [N_DIRECTED] = '{
        '{MODE_ADDI, 5'd0, 5'd1, 16'h7FFF, 32'h0000_0000, 1'b1,
          '{1'b1, 5'd1, 32'h0000_7FFF, 1'b0, 32'h0000_0000, STATUS_OK}},
        '{MODE_ADDI, 5'd0, 5'd2, 16'h8000, 32'h0000_0000, 1'b1,
          '{1'b1, 5'd2, 32'hFFFF_8000, 1'b0, 32'h0000_0000, STATUS_OK}},
        '{MODE_ANDI, 5'd2, 5'd3, 16'hFFFF, 32'h0000_0000, 1'b1,
          '{1'b1, 5'd3, 32'h0000_8000, 1'b0, 32'h0000_0000, STATUS_OK}},
        '{MODE_ADDI, 5'd1, 5'd0, 16'h0005, 32'h0000_0000, 1'b1,
          '{1'b0, 5'd0, 32'h0000_0000, 1'b0, 32'h0000_0000, STATUS_OK}},
        '{MODE_ADDI, 5'd0, 5'd4, 16'h0100, 32'h0000_0000, 1'b1,
          '{1'b1, 5'd4, 32'h0000_0100, 1'b0, 32'h0000_0000, STATUS_OK}},
        '{MODE_SW,   5'd4, 5'd2, 16'h0000, 32'h0000_0000, 1'b1,
          '{1'b0, 5'd0, 32'h0000_0000, 1'b0, 32'h0000_0000, STATUS_OK}},
        '{MODE_LW,   5'd4, 5'd5, 16'h0000, 32'h0000_0000, 1'b1,
          '{1'b1, 5'd5, 32'hFFFF_8000, 1'b0, 32'h0000_0000, STATUS_OK}},
        '{MODE_SW,   5'd4, 5'd1, 16'h0004, 32'h0000_0000, 1'b1,
          '{1'b0, 5'd0, 32'h0000_0000, 1'b0, 32'h0000_0000, STATUS_OK}},
        '{MODE_LW,   5'd4, 5'd6, 16'h0002, 32'h0000_0000, 1'b1,
          '{1'b1, 5'd6, 32'h8000_0000, 1'b0, 32'h0000_0000, STATUS_MISALIGNED}},
        '{MODE_SW,   5'd4, 5'd3, 16'h0001, 32'h0000_0000, 1'b1,
          '{1'b0, 5'd0, 32'h0000_0000, 1'b0, 32'h0000_0000, STATUS_MISALIGNED}},
        '{MODE_LW,   5'd4, 5'd0, 16'h0000, 32'h0000_0000, 1'b1,
          '{1'b0, 5'd0, 32'h0000_0000, 1'b0, 32'h0000_0000, STATUS_OK}},
        '{MODE_LW,   5'd4, 5'd7, 16'h0000, 32'h0000_0000, 1'b0, '0},
        '{MODE_SW,   5'd0, 5'd1, 16'h0FFD, 32'h0000_0000, 1'b1,
          '{1'b0, 5'd0, 32'h0000_0000, 1'b0, 32'h0000_0000, STATUS_RANGE}},
        '{MODE_LW,   5'd2, 5'd8, 16'h0000, 32'h0000_0000, 1'b1,
          '{1'b0, 5'd0, 32'h0000_0000, 1'b0, 32'h0000_0000, STATUS_RANGE}},
        '{MODE_SW,   5'd0, 5'd1, 16'h0FFC, 32'h0000_0000, 1'b1,
          '{1'b0, 5'd0, 32'h0000_0000, 1'b0, 32'h0000_0000, STATUS_OK}},
        '{MODE_LW,   5'd0, 5'd9, 16'h0FFC, 32'h0000_0000, 1'b1,
          '{1'b1, 5'd9, 32'h0000_7FFF, 1'b0, 32'h0000_0000, STATUS_OK}},
        '{MODE_LW,   5'd0, 5'd10, 16'h0FFE, 32'h0000_0000, 1'b1,
          '{1'b0, 5'd0, 32'h0000_0000, 1'b0, 32'h0000_0000, STATUS_RANGE}},
        '{MODE_ADDI, 5'd0, 5'd10, 16'hFFFF, 32'h0000_0000, 1'b1,
          '{1'b1, 5'd10, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000, STATUS_OK}},
        '{MODE_ADDI, 5'd10, 5'd11, 16'h0001, 32'h0000_0000, 1'b1,
          '{1'b1, 5'd11, 32'h0000_0000, 1'b0, 32'h0000_0000, STATUS_OK}},
        '{MODE_BEQ,  5'd1, 5'd1, 16'h7FFF, 32'hFFFF_FFFC, 1'b1,
          '{1'b0, 5'd0, 32'h0000_0000, 1'b1, 32'h0001_FFFC, STATUS_OK}},
        '{MODE_BEQ,  5'd1, 5'd2, 16'h8000, 32'h0000_0000, 1'b1,
          '{1'b0, 5'd0, 32'h0000_0000, 1'b0, 32'hFFFE_0004, STATUS_OK}},
        '{MODE_BNE,  5'd1, 5'd2, 16'hFFFF, 32'h0000_1000, 1'b1,
          '{1'b0, 5'd0, 32'h0000_0000, 1'b1, 32'h0000_1000, STATUS_OK}},
        '{MODE_BNE,  5'd0, 5'd11, 16'h0000, 32'h0000_0100, 1'b1,
          '{1'b0, 5'd0, 32'h0000_0000, 1'b0, 32'h0000_0104, STATUS_OK}},
        '{MODE_RSVD_A, 5'd31, 5'd31, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
          '{1'b0, 5'd0, 32'h0000_0000, 1'b0, 32'h0000_0000, STATUS_OK}},
        '{MODE_RSVD_B, 5'd31, 5'd31, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
          '{1'b0, 5'd0, 32'h0000_0000, 1'b0, 32'h0000_0000, STATUS_OK}}
    };

    logic clk = 1'b0;
    logic rst_n;
    logic cmd_valid;
    logic cmd_stall;
    cmd_t cmd;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    logic [31:0] gpr [NUM_REGS];
    logic [7:0]  dmem [MEM_BYTES];
    bit          dmem_written [MEM_BYTES];
    logic [31:0] stored_words [$];
    rsp_t        pending_results [$];
    int          errors = 0;
    bit          tx_calm = 1'b0;
    bit          rx_calm = 1'b0;

    mips_itype_execute_unit #(
        .MEM_BYTES (MEM_BYTES)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #6 clk = ~clk;

    function automatic status_t mem_status(logic [31:0] addr);
        if (addr > MEM_BYTES - WORD_BYTES)
            return STATUS_RANGE;
        if (addr[1:0] != 2'b00)
            return STATUS_MISALIGNED;
        return STATUS_OK;
    endfunction

    function automatic bit word_ready(logic [31:0] addr);
        for (int k = 0; k < WORD_BYTES; k++)
            if (!dmem_written[addr + k])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic rsp_t execute_itype(cmd_t c);
        rsp_t        r;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [15:0] imm;
        logic [31:0] simm;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] addr;
        logic [31:0] val;
        logic        wr;
        r    = '0;
        rs   = c.instruction_word[25:21];
        rt   = c.instruction_word[20:16];
        imm  = c.instruction_word[15:0];
        simm = {{16{imm[15]}}, imm};
        a    = gpr[rs];
        b    = gpr[rt];
        addr = a + simm;
        val  = '0;
        wr   = 1'b0;
        case (c.mode)
            MODE_ADDI:
            begin
                val = a + simm;
                wr  = 1'b1;
            end
            MODE_ANDI:
            begin
                val = a & {16'h0000, imm};
                wr  = 1'b1;
            end
            MODE_LW:
            begin
                r.status = mem_status(addr);
                if (r.status != STATUS_RANGE)
                begin
                    for (int k = 0; k < WORD_BYTES; k++)
                        val = {val[23:0], dmem[addr + k]};
                    wr = 1'b1;
                end
            end
            MODE_SW:
            begin
                r.status = mem_status(addr);
                if (r.status != STATUS_RANGE)
                begin
                    for (int k = 0; k < WORD_BYTES; k++)
                    begin
                        dmem[addr + k]         = b[31 - 8 * k -: 8];
                        dmem_written[addr + k] = 1'b1;
                    end
                    stored_words.push_back(addr);
                end
            end
            MODE_BEQ, MODE_BNE:
            begin
                r.branch_target = c.current_pc + WORD_BYTES + (simm << 2);
                r.branch_taken  = (c.mode == MODE_BEQ) ? (a == b) : (a != b);
            end
            default:
            begin
            end
        endcase
        if (wr && rt != 5'd0)
        begin
            gpr[rt]          = val;
            r.write_enable   = 1'b1;
            r.write_register = rt;
            r.write_value    = val;
        end
        return r;
    endfunction

    function automatic cmd_t make_req(logic [2:0] m, logic [4:0] rs, logic [4:0] rt,
                                      logic [15:0] imm, logic [31:0] pc);
        cmd_t       c;
        logic [5:0] op_bits;
        op_bits            = 6'($urandom_range(0, 63));
        c.mode             = m;
        c.instruction_word = {op_bits, rs, rt, imm};
        c.current_pc       = pc;
        return c;
    endfunction

    // Target must be within reach of r0 (0..32767 or 0xFFFF8000 and up).
    function automatic cmd_t reach_req(logic [2:0] m, logic [31:0] target);
        logic [4:0]  rs;
        logic [31:0] diff;
        rs   = 5'($urandom_range(0, 31));
        diff = target - gpr[rs];
        if ($signed(diff) < -32768 || $signed(diff) > 32767)
        begin
            rs   = 5'd0;
            diff = target;
        end
        return make_req(m, rs, 5'($urandom_range(0, 31)), diff[15:0], $urandom);
    endfunction

    function automatic logic [31:0] far_addr();
        case ($urandom_range(0, 2))
            0: return $urandom_range(MEM_BYTES - 3, MEM_BYTES - 1);
            1: return $urandom_range(MEM_BYTES, 32767);
            default: return 32'hFFFF_8000 + $urandom_range(0, 32767);
        endcase
    endfunction

    function automatic logic [31:0] load_addr();
        logic [31:0] base;
        logic [31:0] cand;
        if (stored_words.size() == 0)
            return far_addr();
        if ($urandom_range(0, 9) < 4)
            base = stored_words[stored_words.size() - 1];
        else
            base = stored_words[$urandom_range(0, stored_words.size() - 1)];
        if ($urandom_range(0, 9) < 3)
        begin
            cand = base + $urandom_range(0, 6) - 3;
            if (mem_status(cand) == STATUS_RANGE || word_ready(cand))
                return cand;
        end
        return base;
    endfunction

    function automatic cmd_t random_req();
        int unsigned sel;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [31:0] target;
        sel = $urandom_range(0, 99);
        rs  = 5'($urandom_range(0, 31));
        rt  = 5'($urandom_range(0, 31));
        if (sel < 20)
        begin
            if ($urandom_range(0, 2) == 0)
                return make_req(MODE_ADDI, 5'd0, rt, 16'($urandom_range(0, MEM_BYTES - 1)),
                                $urandom);
            return make_req(MODE_ADDI, rs, rt, 16'($urandom), $urandom);
        end
        if (sel < 30)
            return make_req(MODE_ANDI, rs, rt, 16'($urandom), $urandom);
        if (sel < 55)
        begin
            if ($urandom_range(0, 9) == 0)
                target = far_addr();
            else
            begin
                target = $urandom_range(0, MEM_BYTES - WORD_BYTES);
                if ($urandom_range(0, 3) != 0)
                    target[1:0] = 2'b00;
            end
            return reach_req(MODE_SW, target);
        end
        if (sel < 80)
            return reach_req(MODE_LW, ($urandom_range(0, 9) == 0) ? far_addr() : load_addr());
        if (sel < 96)
        begin
            if ($urandom_range(0, 2) == 0)
                rt = rs;
            return make_req((sel < 88) ? MODE_BEQ : MODE_BNE, rs, rt, 16'($urandom), $urandom);
        end
        return make_req(sel[0] ? MODE_RSVD_A : MODE_RSVD_B, rs, rt, 16'($urandom), $urandom);
    endfunction

    task automatic send_request(cmd_t c, logic has_fixed, rsp_t fixed);
        int   gap;
        rsp_t predicted;
        if ($urandom_range(0, 39) == 0)
            tx_calm = !tx_calm;
        gap = tx_calm ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        do
            @(posedge clk);
        while (cmd_stall);
        predicted = execute_itype(c);
        pending_results.push_back(has_fixed ? fixed : predicted);
    endtask

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s expected %h got %h", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic check_result(rsp_t got);
        rsp_t want;
        if (pending_results.size() == 0)
        begin
            $display("%0t ns: result with none expected, got %h", $time, got);
            errors++;
            return;
        end
        want = pending_results.pop_front();
        compare_field("write_enable", 32'(want.write_enable), 32'(got.write_enable));
        compare_field("write_register", 32'(want.write_register), 32'(got.write_register));
        compare_field("write_value", want.write_value, got.write_value);
        compare_field("branch_taken", 32'(want.branch_taken), 32'(got.branch_taken));
        compare_field("branch_target", want.branch_target, got.branch_target);
        compare_field("status", 32'(want.status), 32'(got.status));
    endtask

    always @(posedge clk)
        if (rst_n && rsp_valid && !rsp_stall)
            check_result(rsp);

    initial
    begin
        int wait_cycles;
        int taken_count;
        rsp_stall   = 1'b0;
        taken_count = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                rx_calm = !rx_calm;
            if (taken_count == 150 || taken_count == 450)
                wait_cycles = LONG_HOLD;
            else
                wait_cycles = rx_calm ? 0 : $urandom_range(0, 9);
            if (wait_cycles > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            do
                @(posedge clk);
            while (rsp_valid !== 1'b1);
            taken_count++;
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        cmd       = '0;
        for (int i = 0; i < NUM_REGS; i++)
            gpr[i] = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_request(make_req(DIRECTED[i].mode, DIRECTED[i].rs, DIRECTED[i].rt,
                                  DIRECTED[i].imm, DIRECTED[i].pc),
                         DIRECTED[i].has_fixed, DIRECTED[i].fixed);
        repeat (N_RANDOM)
            send_request(random_req(), 1'b0, '0);
        cmd_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/mite_pkg.sv
hw/rtl/mite_regfile.sv
hw/rtl/mite_dmem.sv
hw/rtl/mite_exec.sv
hw/rtl/mips_itype_execute_unit.sv
tb/sv/tb.sv
